### rtl/tdtb_pkg.sv
// shared types and constants for the thread delay timer bank
package tdtb_pkg;

   localparam int THREAD_COUNT_DEFAULT = 8;
   localparam int THREAD_MAX           = 8;
   localparam int THREAD_W             = 3;
   localparam int DELAY_W              = 16;
   localparam int TICK_W               = 32;

   localparam logic [THREAD_MAX-1:0] RESET_DISABLED = 8'b1111_1110;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_DELAY   = 2'd1,
      OP_ENABLE  = 2'd2,
      OP_DISABLE = 2'd3
   } op_type;

   typedef struct packed {
      logic                go;
      op_type              op;
      logic [THREAD_W-1:0] thread;
      logic [DELAY_W-1:0]  ticks;
   } slot_cmd_type;

   typedef struct packed {
      logic delayed;
      logic disabled;
   } slot_status_type;

endpackage

### rtl/tdtb_slot.sv
// delay counter, delayed bit and disable bit of one thread
module tdtb_slot #(
   parameter int SLOT_ID = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tdtb_pkg::slot_cmd_type cmd,
   output tdtb_pkg::slot_status_type status_in
);

   logic [tdtb_pkg::DELAY_W-1:0] count_ff;
   logic [tdtb_pkg::DELAY_W-1:0] count_in;
   logic                         delayed_ff;
   logic                         delayed_in;
   logic                         disabled_ff;
   logic                         disabled_in;
   logic                         hit;

   assign hit = cmd.thread == tdtb_pkg::THREAD_W'(SLOT_ID);

   always_comb begin
      count_in    = count_ff;
      delayed_in  = delayed_ff;
      disabled_in = disabled_ff;
      if (cmd.go) begin
         unique case (cmd.op)
            tdtb_pkg::OP_TICK: begin
               if (delayed_ff) begin
                  count_in   = count_ff - tdtb_pkg::DELAY_W'(1);
                  delayed_in = count_ff != tdtb_pkg::DELAY_W'(1);
               end
            end
            tdtb_pkg::OP_DELAY: begin
               if (hit && cmd.ticks != '0) begin
                  count_in   = cmd.ticks;
                  delayed_in = 1'b1;
               end
            end
            tdtb_pkg::OP_ENABLE: begin
               if (hit) disabled_in = 1'b0;
            end
            tdtb_pkg::OP_DISABLE: begin
               if (hit) disabled_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         delayed_ff  <= 1'b0;
         disabled_ff <= tdtb_pkg::RESET_DISABLED[SLOT_ID];
      end else begin
         count_ff    <= count_in;
         delayed_ff  <= delayed_in;
         disabled_ff <= disabled_in;
      end
   end

   assign status_in.delayed  = delayed_in;
   assign status_in.disabled = disabled_in;

endmodule

### rtl/thread_delay_timer_bank.sv
// top level: input register, per-thread slots, tick count and result register
// an accepted request passes the input register, then the result register
// one item per cycle when no response is stalled, one response per item
// req_stall rises only while a response is held by rsp_stall
// synchronous reset clears the slot counters, delayed bits and tick count,
// and leaves only thread zero enabled
module thread_delay_timer_bank #(
   parameter int THREAD_COUNT = tdtb_pkg::THREAD_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic [tdtb_pkg::THREAD_W-1:0]        req_thread,
   input  logic [tdtb_pkg::DELAY_W-1:0]         req_delay_ticks,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tdtb_pkg::THREAD_MAX-1:0]      rsp_delayed_mask,
   output logic [tdtb_pkg::THREAD_MAX-1:0]      rsp_disabled_mask,
   output logic [tdtb_pkg::TICK_W-1:0]          rsp_tick_count
);

   logic                                in_valid_ff;
   logic                                in_valid_in;
   tdtb_pkg::op_type                    in_op_ff;
   logic [tdtb_pkg::THREAD_W-1:0]       in_thread_ff;
   logic [tdtb_pkg::DELAY_W-1:0]        in_ticks_ff;
   logic [tdtb_pkg::TICK_W-1:0]         ticks_ff;
   logic [tdtb_pkg::TICK_W-1:0]         ticks_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [tdtb_pkg::THREAD_MAX-1:0]     delayed_ff;
   logic [tdtb_pkg::THREAD_MAX-1:0]     delayed_in;
   logic [tdtb_pkg::THREAD_MAX-1:0]     disabled_ff;
   logic [tdtb_pkg::THREAD_MAX-1:0]     disabled_in;
   logic                                advance;
   logic                                accept;
   tdtb_pkg::slot_cmd_type              cmd;
   tdtb_pkg::slot_status_type           status [THREAD_COUNT];

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign cmd.go     = advance;
   assign cmd.op     = in_op_ff;
   assign cmd.thread = in_thread_ff;
   assign cmd.ticks  = in_ticks_ff;

   for (genvar i = 0; i < THREAD_COUNT; i++) begin : g_slot
      tdtb_slot #(
         .SLOT_ID(i)
      ) u_slot (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .status_in (status[i])
      );
   end

   always_comb begin
      delayed_in  = '0;
      disabled_in = '0;
      for (int i = 0; i < THREAD_COUNT; i++) begin
         delayed_in[i]  = status[i].delayed;
         disabled_in[i] = status[i].disabled;
      end
   end

   assign ticks_in = (advance && in_op_ff == tdtb_pkg::OP_TICK)
                     ? ticks_ff + tdtb_pkg::TICK_W'(1) : ticks_ff;

   assign in_valid_in  = accept || req_stall;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ticks_ff     <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff     <= tdtb_pkg::op_type'(req_opcode);
         in_thread_ff <= req_thread;
         in_ticks_ff  <= req_delay_ticks;
      end
      if (advance) begin
         delayed_ff  <= delayed_in;
         disabled_ff <= disabled_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_delayed_mask  = delayed_ff;
   assign rsp_disabled_mask = disabled_ff;
   assign rsp_tick_count    = ticks_ff;

endmodule

### rtl/tdtb_checker.sv
// port checks for the thread delay timer bank and their bind
module tdtb_checker #(
   parameter int THREAD_COUNT = tdtb_pkg::THREAD_COUNT_DEFAULT
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [tdtb_pkg::THREAD_MAX-1:0]  rsp_delayed_mask,
   input logic [tdtb_pkg::THREAD_MAX-1:0]  rsp_disabled_mask,
   input logic [tdtb_pkg::TICK_W-1:0]      rsp_tick_count
);

   logic [tdtb_pkg::THREAD_MAX-1:0] missing;

   assign missing = ~tdtb_pkg::THREAD_MAX'((9'd1 << THREAD_COUNT) - 9'd1);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response beat dropped");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_delayed_mask | rsp_disabled_mask) & missing) == '0)
      else $error("mask bit set for a missing thread");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall ##1 rsp_valid && !rsp_stall |->
         rsp_tick_count == $past(rsp_tick_count) ||
         rsp_tick_count == $past(rsp_tick_count) + tdtb_pkg::TICK_W'(1))
      else $error("tick count moved by more than one between beats");

endmodule

bind thread_delay_timer_bank tdtb_checker #(
   .THREAD_COUNT(THREAD_COUNT)
) u_tdtb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_delayed_mask  (rsp_delayed_mask),
   .rsp_disabled_mask (rsp_disabled_mask),
   .rsp_tick_count    (rsp_tick_count)
);
